[design/fixed_slot_pool_allocator_assert.svh]
// ----------------------------------------------------------------------------
// fixed slot pool allocator assertion macros
// shared concurrent assertion forms used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FSPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// consequent must hold in the cycle after the antecedent
`define FSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

[design/fspa_pkg.sv]
// ----------------------------------------------------------------------------
// fixed slot pool allocator package
// request and status codes, register indexes, field widths and shared types
// ----------------------------------------------------------------------------
`default_nettype none

package fspa_pkg;

    // request field widths
    localparam int MODE_W     = 2;
    localparam int SLOT_IDX_W = 8;
    localparam int IN_DATA_W  = 16;

    // result field widths
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 6;
    localparam int OFFSET_W   = 18;
    localparam int OUT_DATA_W = 32;

    // configuration register widths
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int SLOT_CNT_W   = 7;
    localparam int SLOT_BYTES_W = 13;
    localparam int ALIGN_W      = 4;
    localparam int SIZE_W       = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_BYTES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALIGN_LOG2 = 2'd2;

    // configuration reset values
    localparam logic [SLOT_CNT_W-1:0]   RST_SLOT_COUNT = 7'd64;
    localparam logic [SLOT_BYTES_W-1:0] RST_SLOT_BYTES = 13'd16;
    localparam logic [ALIGN_W-1:0]      RST_ALIGN_LOG2 = 4'd3;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE_ALL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    // control group toward the link memory
    typedef struct packed {
        logic we;
        logic rd_en;
        logic clear;
    } t_mem_ctl;

endpackage

`default_nettype wire

[design/fspa_link_mem.sv]
// ----------------------------------------------------------------------------
// fspa link memory
// free list link store with one write port, one registered read port and
// per entry valid bits; an entry not written since the last clear reads as
// its rebuilt value (link to the slot below, end mark on slot zero)
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_link_mem #(
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire fspa_pkg::t_mem_ctl           i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire logic [$clog2(DEPTH):0]       i_wdata,   // link, then end mark on top
    input  wire logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic      [$clog2(DEPTH):0]       o_rdata    // link, then end mark on top
);
    import fspa_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [AW:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [AW:0]      r_rdata;
    logic [AW:0]      rebuilt;

    // rebuilt value of the entry at the read address
    always_comb begin
        if (i_raddr == '0) begin
            rebuilt = {1'b1, {AW{1'b0}}};
        end else begin
            rebuilt = {1'b0, AW'(i_raddr - 1'b1)};
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // valid bits, cleared at once on reset and on a full rebuild
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : rebuilt;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/fixed_slot_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed slot pool allocator
// lifo free list of equal slots: alloc pops the head, free pushes an index,
// free all rebuilds the list in descending order
// ----------------------------------------------------------------------------
// Takes one request per clock unless the result stream stalls, and returns its
// result on the output stream in the cycle after acceptance; a full output
// register still accepts a new request in the same cycle it is taken. The head
// slot, its link and end mark live in registers: on a pop the link of the new
// head is fetched through the single registered read port of the link memory,
// which is ready for the next pop in the very next cycle. Free all clears the
// per slot valid bits at once, so there is no clearing pass. The byte offset
// is the granted slot times the slot size rounded up to the alignment, built
// with one multiplier before the output register. The user must write
// configuration registers only while no request is in flight; the block does
// not enforce it. A new slot count applies to the next free or free all.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_pool_allocator #(
    parameter int NUM_SLOTS = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request stream
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire logic [fspa_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,  // mode[1:0], slot_index[9:2]
    // result stream
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    output logic      [fspa_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,  // status[1:0], granted_slot[7:2], byte_offset[25:8]
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [fspa_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [fspa_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import fspa_pkg::*;

    `include "fixed_slot_pool_allocator_assert.svh"

    localparam int IW       = $clog2(NUM_SLOTS);
    localparam int LW       = $clog2(NUM_SLOTS + 1);
    localparam int CW       = (LW > SLOT_IDX_W) ? LW : SLOT_IDX_W;
    localparam int MW       = (IW + SIZE_W > OFFSET_W) ? IW + SIZE_W : OFFSET_W;
    localparam int RST_LIVE = (NUM_SLOTS < int'(RST_SLOT_COUNT)) ? NUM_SLOTS
                                                                 : int'(RST_SLOT_COUNT);

    localparam logic [IW-1:0] RST_HEAD = IW'(RST_LIVE - 1);
    localparam logic [IW-1:0] RST_LINK = IW'(RST_LIVE - 2);

    // configuration registers
    logic [SLOT_CNT_W-1:0]   r_slot_count;
    logic [SLOT_BYTES_W-1:0] r_slot_bytes;
    logic [ALIGN_W-1:0]      r_align_log2;

    // free list head state
    logic          r_run;
    logic [IW-1:0] r_head, n_head;
    logic          r_empty, n_empty;
    logic [IW-1:0] r_ln, n_ln;
    logic          r_le, n_le;
    logic          r_use_mem, n_use_mem;

    // result register
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_status;
    logic [GRANT_W-1:0]  r_grant;
    logic [OFFSET_W-1:0] r_offset;

    // request fields and decode
    logic                  in_acc;
    logic [MODE_W-1:0]     in_mode;
    logic [SLOT_IDX_W-1:0] in_idx;
    logic [CW-1:0]         live;
    logic [CW-1:0]         sc_ext;
    logic                  bad_index;

    // link memory interface
    t_mem_ctl      mem_ctl;
    logic [IW-1:0] wr_link;
    logic          wr_end;
    logic [IW:0]   rd_data;
    logic [IW-1:0] cur_link;
    logic          cur_end;

    // result path
    logic [STATUS_W-1:0] res_status;
    logic                res_hit;
    logic [SIZE_W-1:0]   round_mask;
    logic [SIZE_W-1:0]   unit_bytes;
    logic [MW-1:0]       product;

    // handshake and field unpacking
    assign o_s_axis_tready = r_run & (~r_ovalid | i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign in_mode         = i_s_axis_tdata[MODE_W-1:0];
    assign in_idx          = i_s_axis_tdata[MODE_W+SLOT_IDX_W-1:MODE_W];

    // effective slot count and range check
    assign sc_ext    = CW'(r_slot_count);
    assign live      = (sc_ext > CW'(NUM_SLOTS)) ? CW'(NUM_SLOTS) : sc_ext;
    assign bad_index = CW'(in_idx) >= live;

    // link and end mark of the current head
    assign cur_link = r_use_mem ? rd_data[IW-1:0] : r_ln;
    assign cur_end  = r_use_mem ? rd_data[IW]     : r_le;

    // request processing
    always_comb begin
        n_head     = r_head;
        n_empty    = r_empty;
        n_ln       = r_ln;
        n_le       = r_le;
        n_use_mem  = r_use_mem;
        mem_ctl    = '0;
        wr_link    = '0;
        wr_end     = 1'b1;
        res_status = ST_OK;
        res_hit    = 1'b0;
        if (in_acc) begin
            n_ln      = cur_link;
            n_le      = cur_end;
            n_use_mem = 1'b0;
            unique case (in_mode)
                MODE_ALLOC: begin
                    if (r_empty) begin
                        res_status = ST_NO_SLOT;
                    end else begin
                        res_hit = 1'b1;
                        if (cur_end) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head        = cur_link;
                            n_use_mem     = 1'b1;
                            mem_ctl.rd_en = 1'b1;
                        end
                    end
                end
                MODE_FREE: begin
                    if (bad_index) begin
                        res_status = ST_BAD_INDEX;
                    end else begin
                        wr_link    = r_empty ? '0 : r_head;
                        wr_end     = r_empty;
                        mem_ctl.we = 1'b1;
                        n_head     = IW'(in_idx);
                        n_empty    = 1'b0;
                        n_ln       = wr_link;
                        n_le       = wr_end;
                    end
                end
                MODE_FREE_ALL: begin
                    mem_ctl.clear = 1'b1;
                    if (live == '0) begin
                        n_head  = '0;
                        n_empty = 1'b1;
                        n_ln    = '0;
                        n_le    = 1'b1;
                    end else begin
                        n_head  = IW'(live - 1'b1);
                        n_empty = 1'b0;
                        n_le    = (n_head == '0);
                        n_ln    = n_le ? '0 : IW'(n_head - 1'b1);
                    end
                end
                MODE_UNUSED: begin
                end
                default: begin
                end
            endcase
        end
    end

    // aligned slot size and byte offset of the head slot
    assign round_mask = SIZE_W'((SIZE_W'(1) << r_align_log2) - 1'b1);
    assign unit_bytes = (SIZE_W'(r_slot_bytes) + round_mask) & ~round_mask;
    assign product    = MW'(r_head) * MW'(unit_bytes);

    // link memory
    fspa_link_mem #(
        .DEPTH (NUM_SLOTS)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_waddr (IW'(in_idx)),
        .i_wdata ({wr_end, wr_link}),
        .i_raddr (cur_link),
        .o_rdata (rd_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= RST_SLOT_COUNT;
            r_slot_bytes <= RST_SLOT_BYTES;
            r_align_log2 <= RST_ALIGN_LOG2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SLOT_COUNT: r_slot_count <= i_cfg_wdata[SLOT_CNT_W-1:0];
                CFG_SLOT_BYTES: r_slot_bytes <= i_cfg_wdata[SLOT_BYTES_W-1:0];
                CFG_ALIGN_LOG2: r_align_log2 <= i_cfg_wdata[ALIGN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // head state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_head    <= RST_HEAD;
            r_empty   <= 1'b0;
            r_ln      <= RST_LINK;
            r_le      <= 1'b0;
            r_use_mem <= 1'b0;
        end else begin
            r_run     <= 1'b1;
            r_head    <= n_head;
            r_empty   <= n_empty;
            r_ln      <= n_ln;
            r_le      <= n_le;
            r_use_mem <= n_use_mem;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (in_acc) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= res_status;
            r_grant  <= res_hit ? GRANT_W'(r_head) : '0;
            r_offset <= res_hit ? product[OFFSET_W-1:0] : '0;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - STATUS_W - GRANT_W - OFFSET_W){1'b0}},
                              r_offset, r_grant, r_status};

    // checks
    `FSPA_ASSERT_NEXT(a_alloc_ok, i_clk, i_rst_n, in_acc && in_mode == MODE_ALLOC && !r_empty, o_m_axis_tvalid && r_status == ST_OK)
    `FSPA_ASSERT_NEXT(a_free_fills, i_clk, i_rst_n, in_acc && in_mode == MODE_FREE && !bad_index, !r_empty && r_head == $past(IW'(in_idx)))
    `FSPA_ASSERT_SAME(a_mem_after_pop, i_clk, i_rst_n, $rose(r_use_mem), $past(mem_ctl.rd_en))
    `FSPA_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, r_ovalid && r_status != ST_OK, r_grant == '0 && r_offset == '0)

endmodule

`default_nettype wire

[dv/fixed_slot_pool_allocator_tb.sv]
// ----------------------------------------------------------------------------
// fixed slot pool allocator testbench
// drives alloc, free and free all requests into the allocator stream, keeps
// its own model of the lifo free list and slot geometry, and checks every
// result beat in order. a directed table opens the run, then random phases
// with new register settings follow under varying idle and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_pool_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fspa_pkg::*;

    localparam int POOL_SLOTS = 64;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_REQS = 92;
    localparam int HOLD_CYCLES = 80;

    // one result beat, unpacked from tdata
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  slot;
        logic [OFFSET_W-1:0] offset;
    } t_alloc_result;

    // one row of the directed table: a register write or a request
    typedef struct {
        bit                      is_reg;
        logic [CFG_ADDR_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        logic [MODE_W-1:0]       mode;
        logic [SLOT_IDX_W-1:0]   idx;
        bit                      typed;
        t_alloc_result           want;
    } t_plan_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata = '0;  // mode[1:0], slot_index[9:2]
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;       // status[1:0], granted_slot[7:2], byte_offset[25:8]
    logic                    i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    // predicted allocator state
    logic [SLOT_CNT_W-1:0]   cfg_count;
    logic [SLOT_BYTES_W-1:0] cfg_bytes;
    logic [ALIGN_W-1:0]      cfg_align;
    logic [GRANT_W-1:0]      link_next [POOL_SLOTS];
    bit                      link_last [POOL_SLOTS];
    logic [GRANT_W-1:0]      free_head;
    bit                      free_empty;

    t_alloc_result           pending_results [$];
    t_plan_row               plan [$];
    int                      fail_count = 0;
    int                      tx_idle_pct = 0;
    int                      rx_idle_pct = 0;
    logic                    hold_req = 1'b0;
    int                      hold_left = 0;
    bit                      hold_done = 1'b0;

    fixed_slot_pool_allocator #(
        .NUM_SLOTS(POOL_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // slot count clipped to the pool size
    function automatic int usable_slots();
        int n;
        n = int'(cfg_count);
        if (n > POOL_SLOTS) begin
            n = POOL_SLOTS;
        end
        return n;
    endfunction

    // every slot free, highest usable slot at the head
    function automatic void rebuild_free_list();
        int n;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            link_next[i] = (i == 0) ? '0 : GRANT_W'(i - 1);
            link_last[i] = (i == 0);
        end
        n = usable_slots();
        if (n == 0) begin
            free_head  = '0;
            free_empty = 1'b1;
        end else begin
            free_head  = GRANT_W'(n - 1);
            free_empty = 1'b0;
        end
    endfunction

    // apply one request to the predicted pool and return its result
    function automatic t_alloc_result apply_request(input logic [MODE_W-1:0] mode,
                                                    input logic [SLOT_IDX_W-1:0] idx);
        t_alloc_result r;
        logic [31:0]   mask;
        logic [31:0]   unit;
        logic [31:0]   prod;
        r = '0;
        case (mode)
            MODE_ALLOC: begin
                if (free_empty) begin
                    r.status = ST_NO_SLOT;
                end else begin
                    // slot size rounded up to the alignment
                    mask     = (32'd1 << cfg_align) - 32'd1;
                    unit     = (32'(cfg_bytes) + mask) & ~mask;
                    prod     = unit * 32'(free_head);
                    r.slot   = free_head;
                    r.offset = prod[OFFSET_W-1:0];
                    if (link_last[free_head]) begin
                        free_empty = 1'b1;
                    end else begin
                        free_head = link_next[free_head];
                    end
                end
            end
            MODE_FREE: begin
                if (int'(idx) >= usable_slots()) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    // push onto the head, the slot becomes the chain end if list was empty
                    link_last[idx[GRANT_W-1:0]] = free_empty;
                    link_next[idx[GRANT_W-1:0]] = free_empty ? '0 : free_head;
                    free_head  = idx[GRANT_W-1:0];
                    free_empty = 1'b0;
                end
            end
            MODE_FREE_ALL: begin
                rebuild_free_list();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_plan_row row_req(input logic [MODE_W-1:0] mode,
                                          input logic [SLOT_IDX_W-1:0] idx);
        t_plan_row r;
        r = '{default: '0};
        r.mode = mode;
        r.idx  = idx;
        return r;
    endfunction

    function automatic t_plan_row row_chk(input logic [MODE_W-1:0] mode,
                                          input logic [SLOT_IDX_W-1:0] idx,
                                          input logic [STATUS_W-1:0] status,
                                          input logic [GRANT_W-1:0] slot,
                                          input logic [OFFSET_W-1:0] offset);
        t_plan_row r;
        r = row_req(mode, idx);
        r.typed = 1'b1;
        r.want  = '{status: status, slot: slot, offset: offset};
        return r;
    endfunction

    function automatic t_plan_row row_reg(input logic [CFG_ADDR_W-1:0] reg_idx,
                                          input logic [CFG_DATA_W-1:0] reg_val);
        t_plan_row r;
        r = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = reg_idx;
        r.reg_val = reg_val;
        return r;
    endfunction

    // offer one request beat, then record what it should produce
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [SLOT_IDX_W-1:0] idx,
                            input bit typed, input t_alloc_result want);
        t_alloc_result predicted;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W - MODE_W - SLOT_IDX_W){1'b0}}, idx, mode};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predicted = apply_request(mode, idx);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // register write once the pool has drained; write enable falls with the next request
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (addr)
            CFG_SLOT_COUNT: cfg_count = val[SLOT_CNT_W-1:0];
            CFG_SLOT_BYTES: cfg_bytes = val[SLOT_BYTES_W-1:0];
            CFG_ALIGN_LOG2: cfg_align = val[ALIGN_W-1:0];
            default: ;
        endcase
    endtask

    // result side ready, with one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_alloc_result seen;
        t_alloc_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.status = o_m_axis_tdata[1:0];
            seen.slot   = o_m_axis_tdata[7:2];
            seen.offset = o_m_axis_tdata[25:8];
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result beat: status %0d slot %0d offset %0d",
                             seen.status, seen.slot, seen.offset);
                end
            end else begin
                want = pending_results.pop_front();
                if (seen.status !== want.status || seen.slot !== want.slot ||
                    seen.offset !== want.offset) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected status %0d slot %0d offset %0d, got status %0d slot %0d offset %0d",
                                 want.status, want.slot, want.offset,
                                 seen.status, seen.slot, seen.offset);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #1_000_000;
        $display("fixed_slot_pool_allocator_tb NOT OK");
        $finish;
    end

    // stimulus
    initial begin
        logic [MODE_W-1:0]       mode;
        logic [SLOT_IDX_W-1:0]   idx;
        logic [SLOT_CNT_W-1:0]   new_count;
        logic [SLOT_BYTES_W-1:0] new_bytes;
        logic [ALIGN_W-1:0]      new_align;
        int                      pick;
        int                      n;

        cfg_count = RST_SLOT_COUNT;
        cfg_bytes = RST_SLOT_BYTES;
        cfg_align = RST_ALIGN_LOG2;
        rebuild_free_list();

        // directed table, reset geometry is 16 byte slots on 8 byte alignment
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd63, 18'd1008));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd62, 18'd992));
        plan.push_back(row_chk(MODE_FREE, 8'd255, ST_BAD_INDEX, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_FREE, 8'd64, ST_BAD_INDEX, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_UNUSED, 8'hAA, ST_OK, 6'd0, 18'd0));
        plan.push_back(row_req(MODE_FREE, 8'd63));
        plan.push_back(row_req(MODE_ALLOC, 8'd0));
        plan.push_back(row_req(MODE_FREE, 8'd0));
        plan.push_back(row_chk(MODE_FREE_ALL, 8'd0, ST_OK, 6'd0, 18'd0));
        // new slot count leaves the current list alone until free all
        plan.push_back(row_reg(CFG_SLOT_COUNT, 13'd1));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd63, 18'd1008));
        plan.push_back(row_chk(MODE_FREE_ALL, 8'd0, ST_OK, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_NO_SLOT, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_FREE, 8'd1, ST_BAD_INDEX, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_FREE, 8'd0, ST_OK, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd0, 18'd0));
        // zero slots: every free is out of range, free all leaves nothing
        plan.push_back(row_reg(CFG_SLOT_COUNT, 13'd0));
        plan.push_back(row_chk(MODE_FREE, 8'd0, ST_BAD_INDEX, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_FREE_ALL, 8'd0, ST_OK, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_NO_SLOT, 6'd0, 18'd0));
        // count above the pool clips, 4096 byte slots on 4096 byte alignment
        plan.push_back(row_reg(CFG_SLOT_COUNT, 13'd127));
        plan.push_back(row_reg(CFG_SLOT_BYTES, 13'd4096));
        plan.push_back(row_reg(CFG_ALIGN_LOG2, 13'd12));
        plan.push_back(row_chk(MODE_FREE_ALL, 8'd0, ST_OK, 6'd0, 18'd0));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd63, 18'd258048));
        // zero slot size gives zero offsets, one byte slots round up to the alignment
        plan.push_back(row_reg(CFG_SLOT_BYTES, 13'd0));
        plan.push_back(row_reg(CFG_ALIGN_LOG2, 13'd0));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd62, 18'd0));
        plan.push_back(row_reg(CFG_SLOT_BYTES, 13'd1));
        plan.push_back(row_reg(CFG_ALIGN_LOG2, 13'd12));
        plan.push_back(row_chk(MODE_ALLOC, 8'd0, ST_OK, 6'd61, 18'd249856));
        // full width size and alignment, offset wraps
        plan.push_back(row_reg(CFG_SLOT_BYTES, 13'd8191));
        plan.push_back(row_reg(CFG_ALIGN_LOG2, 13'd15));
        plan.push_back(row_req(MODE_ALLOC, 8'd0));
        plan.push_back(row_req(MODE_FREE, 8'd1));

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_req(plan[i].mode, plan[i].idx, plan[i].typed, plan[i].want);
            end
        end

        // random phases, each with its own geometry; the idle pattern changes every two phases
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                new_count = SLOT_CNT_W'($urandom_range(65, 127));
            end else if (pick == 1) begin
                new_count = '0;
            end else if (pick < 6) begin
                new_count = SLOT_CNT_W'($urandom_range(1, 6));
            end else begin
                new_count = SLOT_CNT_W'($urandom_range(7, 64));
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
                new_bytes = ($urandom_range(1) != 0) ? 13'd4096 : 13'd1;
            end else if (pick == 1) begin
                new_bytes = SLOT_BYTES_W'($urandom_range(0, 8191));
            end else begin
                new_bytes = SLOT_BYTES_W'($urandom_range(1, 4096));
            end
            new_align = ($urandom_range(9) == 0) ? ALIGN_W'($urandom_range(13, 15))
                                                 : ALIGN_W'($urandom_range(0, 12));
            write_reg(CFG_SLOT_COUNT, 13'(new_count));
            write_reg(CFG_SLOT_BYTES, new_bytes);
            write_reg(CFG_ALIGN_LOG2, 13'(new_align));

            if (ph < 2) begin
                tx_idle_pct = 22;
                rx_idle_pct = 86;
            end else if (ph < 4) begin
                tx_idle_pct = 86;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                // long result stall while requests keep coming
                hold_req <= 1'b1;
            end

            send_req(MODE_FREE_ALL, SLOT_IDX_W'($urandom_range(255)), 1'b0, '0);
            for (int k = 1; k < PHASE_REQS; k++) begin
                n    = usable_slots();
                pick = $urandom_range(99);
                idx  = SLOT_IDX_W'($urandom_range(255));
                if (pick < 45) begin
                    mode = MODE_ALLOC;
                end else if (pick < 87) begin
                    mode = MODE_FREE;
                    if (n > 0 && $urandom_range(3) != 0) begin
                        idx = SLOT_IDX_W'($urandom_range(n - 1));
                    end
                end else if (pick < 95) begin
                    mode = MODE_FREE_ALL;
                end else begin
                    mode = MODE_UNUSED;
                end
                send_req(mode, idx, 1'b0, '0);
            end
        end

        // drain
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("fixed_slot_pool_allocator_tb OK");
        end else begin
            $display("fixed_slot_pool_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
